// File: rtl/core/rsfifo_pkg.sv
`default_nettype none

package rsfifo_pkg;

    localparam int DEPTH_DEFAULT          = 16;
    localparam int RESERVED_SLOTS_DEFAULT = 2;
    localparam int MAX_COMMANDS_DEFAULT   = 8;
    localparam int PAYLOAD_BITS_DEFAULT   = 40;

    localparam int COUNT_BITS         = 4;
    localparam int MASK_BITS          = 8;
    localparam int FIELD_PAYLOAD_BITS = 40;
    localparam int LEVEL_BITS         = 5;

    localparam logic [1:0] OP_ENQUEUE = 2'd0;
    localparam logic [1:0] OP_DEQUEUE = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_EMPTY_BATCH = 3'd1,
        ST_TOO_MANY    = 3'd2,
        ST_BAD_SAFETY  = 3'd3,
        ST_FULL        = 3'd4,
        ST_QUEUE_EMPTY = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]                    operation;
        logic [COUNT_BITS-1:0]         batch_count;
        logic [MASK_BITS-1:0]          safety_mask;
        logic [MASK_BITS-1:0]          off_mask;
        logic [FIELD_PAYLOAD_BITS-1:0] command_payload;
    } cmd_word_t;

    typedef struct packed {
        status_t                       status;
        logic [COUNT_BITS-1:0]         out_count;
        logic [MASK_BITS-1:0]          out_safety_mask;
        logic [MASK_BITS-1:0]          out_off_mask;
        logic [FIELD_PAYLOAD_BITS-1:0] out_payload;
        logic [LEVEL_BITS-1:0]         level;
        logic                          is_empty;
        logic                          is_full;
    } rsp_word_t;

    typedef struct packed {
        status_t status;
        logic    push;
        logic    pop;
        logic    clear;
    } decision_t;

endpackage

`default_nettype wire

// File: rtl/core/rsfifo_admit.sv
`default_nettype none

module rsfifo_admit #(
    parameter int DEPTH          = rsfifo_pkg::DEPTH_DEFAULT,
    parameter int RESERVED_SLOTS = rsfifo_pkg::RESERVED_SLOTS_DEFAULT,
    parameter int MAX_COMMANDS   = rsfifo_pkg::MAX_COMMANDS_DEFAULT,
    parameter int OCC_BITS       = $clog2(DEPTH + 1)
) (
    input  rsfifo_pkg::cmd_word_t cmd,
    input  logic [OCC_BITS-1:0]   occupancy,
    output rsfifo_pkg::decision_t decision
);

    localparam int CAP_ORDINARY = (RESERVED_SLOTS >= DEPTH) ? 0 : DEPTH - RESERVED_SLOTS;
    localparam logic [OCC_BITS-1:0] CAP_ORD_L = OCC_BITS'(CAP_ORDINARY);
    localparam logic [OCC_BITS-1:0] CAP_ALL_L = OCC_BITS'(DEPTH);
    localparam logic [rsfifo_pkg::COUNT_BITS:0] MAX_L =
        (rsfifo_pkg::COUNT_BITS + 1)'(MAX_COMMANDS);
    localparam logic [rsfifo_pkg::COUNT_BITS-1:0] EIGHT =
        rsfifo_pkg::COUNT_BITS'(rsfifo_pkg::MASK_BITS);

    logic [rsfifo_pkg::MASK_BITS:0]   live_wide;
    logic [rsfifo_pkg::MASK_BITS-1:0] live;
    logic                             has_safety;
    logic                             safety_off;
    logic                             no_room;

    always_comb
    begin
        live_wide  = ({{rsfifo_pkg::MASK_BITS{1'b0}}, 1'b1} << cmd.batch_count[2:0])
                     - {{rsfifo_pkg::MASK_BITS{1'b0}}, 1'b1};
        live       = (cmd.batch_count >= EIGHT) ? '1 : live_wide[rsfifo_pkg::MASK_BITS-1:0];
        has_safety = |(cmd.safety_mask & live);
        safety_off = (cmd.batch_count <= EIGHT)
                     && ((cmd.safety_mask & cmd.off_mask & live) == live);
        no_room    = occupancy >= (safety_off ? CAP_ALL_L : CAP_ORD_L);
    end

    always_comb
    begin
        decision.status = rsfifo_pkg::ST_OK;
        decision.push   = 1'b0;
        decision.pop    = 1'b0;
        decision.clear  = 1'b0;
        unique case (cmd.operation)
            rsfifo_pkg::OP_ENQUEUE:
            begin
                if (cmd.batch_count == '0)
                begin
                    decision.status = rsfifo_pkg::ST_EMPTY_BATCH;
                end
                else if ({1'b0, cmd.batch_count} > MAX_L)
                begin
                    decision.status = rsfifo_pkg::ST_TOO_MANY;
                end
                else if (has_safety && !safety_off)
                begin
                    decision.status = rsfifo_pkg::ST_BAD_SAFETY;
                end
                else if (no_room)
                begin
                    decision.status = rsfifo_pkg::ST_FULL;
                end
                else
                begin
                    decision.push = 1'b1;
                end
            end
            rsfifo_pkg::OP_DEQUEUE:
            begin
                if (occupancy == '0)
                begin
                    decision.status = rsfifo_pkg::ST_QUEUE_EMPTY;
                end
                else
                begin
                    decision.pop = 1'b1;
                end
            end
            rsfifo_pkg::OP_CLEAR:
            begin
                decision.clear = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rsfifo_store.sv
`default_nettype none

module rsfifo_store #(
    parameter int DEPTH      = rsfifo_pkg::DEPTH_DEFAULT,
    parameter int ENTRY_BITS = 20 + rsfifo_pkg::PAYLOAD_BITS_DEFAULT,
    parameter int ADDR_BITS  = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  logic [ENTRY_BITS-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output logic [ENTRY_BITS-1:0] rd_data
);

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/core/reserved_slot_command_fifo_top.sv
// A word accepted on cmd is registered in the input stage, its response in the output
// stage. Throughput: one word per cycle when rsp is not stalled; the admission check,
// the pointer and occupancy update and the batch store access occur in the same cycle.
// Reset clears the pointers, the occupancy and both stage valid flags.
// The batch store is not cleared and needs no clearing pass.
`default_nettype none

module reserved_slot_command_fifo_top #(
    parameter int DEPTH          = rsfifo_pkg::DEPTH_DEFAULT,
    parameter int RESERVED_SLOTS = rsfifo_pkg::RESERVED_SLOTS_DEFAULT,
    parameter int MAX_COMMANDS   = rsfifo_pkg::MAX_COMMANDS_DEFAULT,
    parameter int PAYLOAD_BITS   = rsfifo_pkg::PAYLOAD_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  rsfifo_pkg::cmd_word_t cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsfifo_pkg::rsp_word_t rsp
);

    localparam int PTR_BITS   = $clog2(DEPTH);
    localparam int OCC_BITS   = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS = rsfifo_pkg::COUNT_BITS + 2 * rsfifo_pkg::MASK_BITS + PAYLOAD_BITS;
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [OCC_BITS-1:0] FULL_OCC = OCC_BITS'(DEPTH);
    localparam logic [OCC_BITS:0]   DEPTH_W  = (OCC_BITS + 1)'(DEPTH);

    logic                  in_valid_reg;
    rsfifo_pkg::cmd_word_t in_word_reg;

    logic                  rsp_valid_reg;
    rsfifo_pkg::status_t   status_reg;
    logic [rsfifo_pkg::LEVEL_BITS-1:0] level_reg;
    logic                  empty_reg;
    logic                  full_reg;
    logic                  deq_reg;

    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [OCC_BITS-1:0]   occ_reg;
    logic [OCC_BITS-1:0]   occ_next;

    logic                  out_load;
    logic                  process;
    rsfifo_pkg::decision_t decision;
    logic [ENTRY_BITS-1:0] wr_entry;
    logic [ENTRY_BITS-1:0] rd_entry;

    assign out_load  = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = in_valid_reg && !out_load;
    assign process   = in_valid_reg && out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            in_word_reg <= cmd;
        end
    end

    rsfifo_admit #(
        .DEPTH          (DEPTH),
        .RESERVED_SLOTS (RESERVED_SLOTS),
        .MAX_COMMANDS   (MAX_COMMANDS),
        .OCC_BITS       (OCC_BITS)
    ) u_admit (
        .cmd       (in_word_reg),
        .occupancy (occ_reg),
        .decision  (decision)
    );

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        occ_next    = occ_reg;
        if (decision.clear)
        begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
            occ_next    = '0;
        end
        else if (decision.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            occ_next    = occ_reg + 1'b1;
        end
        else if (decision.pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            occ_next    = occ_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else if (process)
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    assign wr_entry = {in_word_reg.batch_count, in_word_reg.safety_mask,
                       in_word_reg.off_mask, in_word_reg.command_payload[PAYLOAD_BITS-1:0]};

    rsfifo_store #(
        .DEPTH      (DEPTH),
        .ENTRY_BITS (ENTRY_BITS),
        .ADDR_BITS  (PTR_BITS)
    ) u_store (
        .clk     (clk),
        .wr_en   (process && decision.push),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_entry),
        .rd_en   (process && decision.pop),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            rsp_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            status_reg <= decision.status;
            level_reg  <= rsfifo_pkg::LEVEL_BITS'(occ_next);
            empty_reg  <= (occ_next == '0);
            full_reg   <= (occ_next == FULL_OCC);
            deq_reg    <= decision.pop;
        end
    end

    assign rsp_valid           = rsp_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.out_count       = deq_reg ? rd_entry[ENTRY_BITS-1 -: rsfifo_pkg::COUNT_BITS] : '0;
    assign rsp.out_safety_mask = deq_reg
        ? rd_entry[PAYLOAD_BITS + rsfifo_pkg::MASK_BITS +: rsfifo_pkg::MASK_BITS] : '0;
    assign rsp.out_off_mask    = deq_reg
        ? rd_entry[PAYLOAD_BITS +: rsfifo_pkg::MASK_BITS] : '0;
    assign rsp.out_payload     = deq_reg
        ? rsfifo_pkg::FIELD_PAYLOAD_BITS'(rd_entry[PAYLOAD_BITS-1:0]) : '0;
    assign rsp.level           = level_reg;
    assign rsp.is_empty        = empty_reg;
    assign rsp.is_full         = full_reg;

    logic [OCC_BITS:0] ptr_sum;
    logic [OCC_BITS:0] ptr_wrap;

    always_comb
    begin
        ptr_sum  = (OCC_BITS + 1)'(rd_ptr_reg) + (OCC_BITS + 1)'(occ_reg);
        ptr_wrap = (ptr_sum >= DEPTH_W) ? ptr_sum - DEPTH_W : ptr_sum;
    end

    // The occupancy never exceeds the number of slots.
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= FULL_OCC)
        else $error("occupancy above depth");

    // The write pointer always sits occupancy slots past the read pointer.
    assert property (@(posedge clk) disable iff (!rst_n)
        PTR_BITS'(ptr_wrap) == wr_ptr_reg)
        else $error("pointers disagree with occupancy");

    // Apart from a drop to zero, as on a clear, the occupancy moves by at most one per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(occ_reg) && occ_reg != '0 |->
            (occ_reg == $past(occ_reg) + 1'b1) || (occ_reg == $past(occ_reg) - 1'b1))
        else $error("occupancy jumped");

    // A batch is never taken from an empty queue or written to a full one.
    assert property (@(posedge clk) disable iff (!rst_n)
        process && (decision.pop || decision.push) |->
            (decision.pop ? occ_reg != '0 : occ_reg != FULL_OCC))
        else $error("store access out of bounds");

endmodule

`default_nettype wire

// File: test/tb_reserved_slot_command_fifo_top.sv
module tb_reserved_slot_command_fifo_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = rsfifo_pkg::DEPTH_DEFAULT;
    localparam int RESERVED_SLOTS = rsfifo_pkg::RESERVED_SLOTS_DEFAULT;
    localparam int MAX_COMMANDS   = rsfifo_pkg::MAX_COMMANDS_DEFAULT;
    localparam int PAYLOAD_BITS   = rsfifo_pkg::PAYLOAD_BITS_DEFAULT;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1130;
    localparam int TAIL_ITEMS     = 150;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef enum int {
        FILL_BIAS,
        DRAIN_BIAS,
        MIXED_BIAS
    } traffic_mode_t;

    typedef struct packed {
        logic [rsfifo_pkg::COUNT_BITS-1:0]         count;
        logic [rsfifo_pkg::MASK_BITS-1:0]          safety;
        logic [rsfifo_pkg::MASK_BITS-1:0]          off;
        logic [rsfifo_pkg::FIELD_PAYLOAD_BITS-1:0] payload;
    } batch_slot_t;

    class batch_fifo_scoreboard;
        batch_slot_t           slots[DEPTH];
        int                    rd_ptr;
        int                    wr_ptr;
        int                    fill;
        rsfifo_pkg::rsp_word_t expected_q[$];
        int                    fails;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            fill   = 0;
            fails  = 0;
        endfunction

        function rsfifo_pkg::rsp_word_t predict_response(rsfifo_pkg::cmd_word_t w);
            rsfifo_pkg::rsp_word_t r;
            logic [7:0]            live;
            logic                  safety_off;
            int                    cap;
            logic [63:0]           pmask;
            r        = '0;
            r.status = rsfifo_pkg::ST_OK;
            pmask    = (64'd1 << PAYLOAD_BITS) - 64'd1;
            if (w.operation == rsfifo_pkg::OP_ENQUEUE)
            begin
                if (w.batch_count == 0)
                begin
                    r.status = rsfifo_pkg::ST_EMPTY_BATCH;
                end
                else if (int'(w.batch_count) > MAX_COMMANDS)
                begin
                    r.status = rsfifo_pkg::ST_TOO_MANY;
                end
                else
                begin
                    live = (w.batch_count >= 8) ? 8'hFF : 8'((1 << w.batch_count) - 1);
                    safety_off = (w.batch_count <= 8)
                                 && ((w.safety_mask & w.off_mask & live) == live);
                    if ((w.safety_mask & live) != 8'h00 && !safety_off)
                    begin
                        r.status = rsfifo_pkg::ST_BAD_SAFETY;
                    end
                    else
                    begin
                        if (safety_off)
                            cap = DEPTH;
                        else if (RESERVED_SLOTS >= DEPTH)
                            cap = 0;
                        else
                            cap = DEPTH - RESERVED_SLOTS;
                        if (fill >= cap)
                        begin
                            r.status = rsfifo_pkg::ST_FULL;
                        end
                        else
                        begin
                            slots[wr_ptr].count   = w.batch_count;
                            slots[wr_ptr].safety  = w.safety_mask;
                            slots[wr_ptr].off     = w.off_mask;
                            slots[wr_ptr].payload = w.command_payload
                                & pmask[rsfifo_pkg::FIELD_PAYLOAD_BITS-1:0];
                            wr_ptr = (wr_ptr + 1) % DEPTH;
                            fill++;
                        end
                    end
                end
            end
            else if (w.operation == rsfifo_pkg::OP_DEQUEUE)
            begin
                if (fill == 0)
                begin
                    r.status = rsfifo_pkg::ST_QUEUE_EMPTY;
                end
                else
                begin
                    r.out_count       = slots[rd_ptr].count;
                    r.out_safety_mask = slots[rd_ptr].safety;
                    r.out_off_mask    = slots[rd_ptr].off;
                    r.out_payload     = slots[rd_ptr].payload;
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill--;
                end
            end
            else if (w.operation == rsfifo_pkg::OP_CLEAR)
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                fill   = 0;
            end
            r.level    = rsfifo_pkg::LEVEL_BITS'(fill);
            r.is_empty = (fill == 0);
            r.is_full  = (fill == DEPTH);
            return r;
        endfunction

        function void note_cmd_word(rsfifo_pkg::cmd_word_t w);
            expected_q.push_back(predict_response(w));
        endfunction

        function string describe(rsfifo_pkg::rsp_word_t r);
            return $sformatf({"status=%0d count=%0d safety=%h off=%h payload=%h",
                              " level=%0d empty=%b full=%b"},
                             r.status, r.out_count, r.out_safety_mask, r.out_off_mask,
                             r.out_payload, r.level, r.is_empty, r.is_full);
        endfunction

        function void check_rsp_word(rsfifo_pkg::rsp_word_t got);
            rsfifo_pkg::rsp_word_t exp;
            logic                  bad;
            if (expected_q.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("Unexpected response word: %s", describe(got));
                return;
            end
            exp = expected_q.pop_front();
            bad = (got.status !== exp.status)
                  || (got.out_count !== exp.out_count)
                  || (got.out_safety_mask !== exp.out_safety_mask)
                  || (got.out_off_mask !== exp.out_off_mask)
                  || (got.out_payload !== exp.out_payload)
                  || (got.level !== exp.level)
                  || (got.is_empty !== exp.is_empty)
                  || (got.is_full !== exp.is_full);
            if (bad)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                begin
                    $display("Response mismatch, expected: %s", describe(exp));
                    $display("Response mismatch, actual:   %s", describe(got));
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_stall;
    rsfifo_pkg::cmd_word_t cmd;
    logic                  rsp_valid;
    logic                  rsp_stall;
    rsfifo_pkg::rsp_word_t rsp;

    batch_fifo_scoreboard sb;
    bit                   quiet_tail;

    reserved_slot_command_fifo_top #(
        .DEPTH          (DEPTH),
        .RESERVED_SLOTS (RESERVED_SLOTS),
        .MAX_COMMANDS   (MAX_COMMANDS),
        .PAYLOAD_BITS   (PAYLOAD_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rsfifo_pkg::cmd_word_t make_cmd(logic [1:0] op, int count,
                                                       logic [7:0] safety, logic [7:0] off,
                                                       logic [39:0] payload);
        rsfifo_pkg::cmd_word_t w;
        w.operation       = op;
        w.batch_count     = rsfifo_pkg::COUNT_BITS'(count);
        w.safety_mask     = safety;
        w.off_mask        = off;
        w.command_payload = payload;
        return w;
    endfunction

    function automatic rsfifo_pkg::cmd_word_t random_word(traffic_mode_t mode);
        rsfifo_pkg::cmd_word_t w;
        int                    roll;
        int                    enq_pct;
        logic [7:0]            live;
        logic [63:0]           bits;
        bits              = {$urandom, $urandom};
        w.command_payload = bits[39:0];
        w.safety_mask     = 8'($urandom);
        w.off_mask        = 8'($urandom);
        w.batch_count     = rsfifo_pkg::COUNT_BITS'($urandom_range(1, MAX_COMMANDS));
        enq_pct = (mode == FILL_BIAS) ? 80 : ((mode == DRAIN_BIAS) ? 20 : 50);
        roll = $urandom_range(0, 99);
        if (roll < 1)
            w.operation = rsfifo_pkg::OP_CLEAR;
        else if (roll < 2)
            w.operation = OP_UNUSED;
        else if (roll < 2 + enq_pct)
            w.operation = rsfifo_pkg::OP_ENQUEUE;
        else
            w.operation = rsfifo_pkg::OP_DEQUEUE;
        live = (w.batch_count >= 8) ? 8'hFF : 8'((1 << w.batch_count) - 1);
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            w.safety_mask = w.safety_mask & ~live;
        end
        else if (roll < 85)
        begin
            w.safety_mask = w.safety_mask | live;
            w.off_mask    = w.off_mask | live;
        end
        else
        begin
            w.batch_count = rsfifo_pkg::COUNT_BITS'($urandom);
        end
        return w;
    endfunction

    task automatic send_word(input rsfifo_pkg::cmd_word_t w);
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        sb.note_cmd_word(w);
    endtask

    task automatic idle_for(input int cycles);
        cmd_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    initial
    begin
        rsfifo_pkg::cmd_word_t directed[$];
        rsfifo_pkg::cmd_word_t w;
        traffic_mode_t         mode;
        int                    sent;
        int                    burst_len;
        int                    rate;
        sb         = new();
        quiet_tail = 1'b0;
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(make_cmd(OP_UNUSED, 0, 8'h00, 8'h00, 40'h0));
        directed.push_back(make_cmd(rsfifo_pkg::OP_DEQUEUE, 0, 8'h00, 8'h00, 40'h0));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 0, 8'h00, 8'h00, 40'h1));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 15, 8'hFF, 8'hFF,
                                    40'hFF_FFFF_FFFF));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 9, 8'h00, 8'h00, 40'h2));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 8, 8'h00, 8'hFF,
                                    40'hFF_FFFF_FFFF));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 8, 8'hFF, 8'hFF, 40'h0));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 3, 8'h01, 8'h01, 40'h3));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 3, 8'h07, 8'h03, 40'h4));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 1, 8'hFE, 8'h00,
                                    40'hA5_5A5A_A55A));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 2, 8'hFC, 8'h03,
                                    40'h5A_A5A5_5AA5));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 1, 8'h01, 8'h01,
                                    40'h80_0000_0001));
        repeat (5)
            directed.push_back(make_cmd(rsfifo_pkg::OP_DEQUEUE, 0, 8'h00, 8'h00, 40'h0));
        directed.push_back(make_cmd(rsfifo_pkg::OP_ENQUEUE, 4, 8'h00, 8'h0F,
                                    40'h12_3456_789A));
        directed.push_back(make_cmd(rsfifo_pkg::OP_CLEAR, 0, 8'h00, 8'h00, 40'h0));
        directed.push_back(make_cmd(rsfifo_pkg::OP_DEQUEUE, 0, 8'h00, 8'h00, 40'h0));
        directed.push_back(make_cmd(OP_UNUSED, 15, 8'hFF, 8'hFF, 40'hFF_FFFF_FFFF));
        foreach (directed[i])
            send_word(directed[i]);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            mode      = traffic_mode_t'($urandom_range(0, 2));
            burst_len = $urandom_range(10, 40);
            rate      = $urandom_range(0, 3);
            repeat (burst_len)
            begin
                quiet_tail = (sent >= RANDOM_ITEMS - TAIL_ITEMS);
                w = random_word(mode);
                send_word(w);
                if (w.operation != OP_UNUSED)
                    sent++;
                if (!quiet_tail && rate != 0 && $urandom_range(0, 9) < rate)
                    idle_for($urandom_range(1, 7));
            end
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int hold;
        int rate;
        int cycles;
        int received;
        bit pressure_done;
        hold          = 0;
        rate          = 2;
        cycles        = 0;
        received      = 0;
        pressure_done = 1'b0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_stall == 1'b0)
            begin
                sb.check_rsp_word(rsp);
                received++;
            end
            cycles++;
            if (cycles % 128 == 0)
                rate = $urandom_range(0, 3);
            if (!pressure_done && received >= HOLD_AFTER)
            begin
                pressure_done = 1'b1;
                hold          = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_tail && rate != 0 && $urandom_range(0, 9) < rate)
            begin
                hold = $urandom_range(1, 7) - 1;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((cmd_valid === 1'b1 && cmd_stall === 1'b0)
                || (rsp_valid === 1'b1 && rsp_stall === 1'b0))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
